/* rtl/dls_pkg.sv */
// Shared types, constants and sigmoid table generator for the dense sigmoid layer.
package dls_pkg;

  localparam int MAX_NODES_DEF   = 16;
  localparam int MAX_INPUTS_DEF  = 64;
  localparam int TABLE_DEPTH_DEF = 256;

  localparam int VALUE_W = 16;
  localparam int ACT_W   = 16;
  localparam int ACC_W   = 40;
  localparam int PROD_W  = 2 * VALUE_W;
  localparam int FRAC_W  = 12;

  localparam int NODE_COUNT_W  = 5;
  localparam int INPUT_COUNT_W = 7;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_ADDR_W    = 3;

  localparam logic [VALUE_W-1:0] WEIGHT_RESET = 16'd2048;

  localparam logic MODE_WEIGHT = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  localparam logic REG_NODE_COUNT  = 1'b0;
  localparam logic REG_INPUT_COUNT = 1'b1;

  localparam logic [63:0] Q62_ONE = 64'd1 << 62;

  typedef struct packed {
    logic               mode;
    logic [3:0]         node_index;
    logic [6:0]         weight_index;
    logic signed [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  neuron;
    logic [15:0] activation;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic clear_en;
    logic wr_en;
    logic load_sample;
    logic issue;
    logic first;
    logic emit_load;
    logic emit_last;
  } dls_cmd_t;

  typedef struct packed {
    logic clear_last;
  } dls_stat_t;

  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return p[125:62];
  endfunction

  // entry i = round(65535 / (1 + exp(-(i - depth/2)/16)))
  function automatic logic [15:0] sig_entry(input int idx, input int depth);
    logic [63:0] t;
    logic [63:0] c;
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] d;
    int          half;
    int          k;
    half = depth >> 1;
    t    = Q62_ONE;
    c    = Q62_ONE;
    e    = Q62_ONE;
    for (int n = 1; n <= 20; n++) begin
      t = udiv64(t, 64'(16 * n));
      if ((n & 1) != 0) c = c - t;
      else c = c + t;
    end
    k = (idx >= half) ? idx - half : half - idx;
    for (int j = 0; j < k; j++) begin
      e = mul_q62(e, c);
    end
    d   = (Q62_ONE + e) >> 15;
    num = (idx >= half) ? (64'd65535 << 47) : (64'd65535 * (e >> 15));
    return 16'(udiv64(num + (d >> 1), d));
  endfunction

endpackage

/* rtl/dls_ram.sv */
// Generic RAM: one write port, two registered read ports.
module dls_ram #(
  parameter  int WIDTH = 16,
  parameter  int DEPTH = 1024,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* rtl/dls_ctrl.sv */
// Controller: clearing pass, sample MAC sweep, activation emission and output valid.
module dls_ctrl #(
  parameter  int MAX_NODES  = 16,
  parameter  int MAX_INPUTS = 64,
  localparam int NW         = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1,
  localparam int SCW        = $clog2(MAX_INPUTS + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_mode,
  output logic                              in_stall,
  output logic                              out_valid,
  input  logic                              out_stall,
  input  logic [dls_pkg::NODE_COUNT_W-1:0]  node_count,
  input  logic [dls_pkg::INPUT_COUNT_W-1:0] input_count,
  input  dls_pkg::dls_stat_t                stat,
  output dls_pkg::dls_cmd_t                 cmd,
  output logic [NW-1:0]                     node_sel,
  output logic [SCW-1:0]                    sample_idx
);

  import dls_pkg::*;

  localparam int CYW = $clog2(MAX_NODES + 2);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_MAC   = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t         state_r, state_nxt;
  logic [CYW-1:0] cyc_r, cyc_nxt;
  logic [SCW-1:0] sc_r, sc_nxt;
  logic [NW-1:0]  emit_r, emit_nxt;
  logic           out_valid_r, out_valid_nxt;

  logic           in_acc;
  logic           out_free;
  logic [NW:0]    nodes_eff;
  logic [SCW-1:0] inputs_eff;
  logic [SCW-1:0] sc_plus;

  always_comb begin
    if (node_count == '0) begin
      nodes_eff = (NW + 1)'(1);
    end else if (32'(node_count) > 32'(MAX_NODES)) begin
      nodes_eff = (NW + 1)'(MAX_NODES);
    end else begin
      nodes_eff = (NW + 1)'(node_count);
    end
    if (input_count == '0) begin
      inputs_eff = SCW'(1);
    end else if (32'(input_count) > 32'(MAX_INPUTS)) begin
      inputs_eff = SCW'(MAX_INPUTS);
    end else begin
      inputs_eff = SCW'(input_count);
    end
  end

  assign in_stall   = (state_r != ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign out_valid  = out_valid_r;
  assign sc_plus    = sc_r + SCW'(1);
  assign sample_idx = sc_r;
  assign node_sel   = (state_r == ST_EMIT) ? emit_r : cyc_r[NW-1:0];

  always_comb begin
    cmd.clear_en    = (state_r == ST_CLEAR);
    cmd.wr_en       = in_acc && (in_mode == MODE_WEIGHT);
    cmd.load_sample = in_acc && (in_mode == MODE_SAMPLE);
    cmd.issue       = (state_r == ST_MAC) && (32'(cyc_r) < 32'(MAX_NODES));
    cmd.first       = (sc_r == '0);
    cmd.emit_load   = (state_r == ST_EMIT) && out_free;
    cmd.emit_last   = ((NW + 1)'(emit_r) == nodes_eff - (NW + 1)'(1));
  end

  always_comb begin
    state_nxt = state_r;
    cyc_nxt   = cyc_r;
    sc_nxt    = sc_r;
    emit_nxt  = emit_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (stat.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd.load_sample) begin
          cyc_nxt   = '0;
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        cyc_nxt = cyc_r + CYW'(1);
        if (32'(cyc_r) == MAX_NODES + 1) begin
          if (sc_plus >= inputs_eff) begin
            sc_nxt    = '0;
            emit_nxt  = '0;
            state_nxt = ST_EMIT;
          end else begin
            sc_nxt    = sc_plus;
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_EMIT: begin
        if (cmd.emit_load) begin
          if (cmd.emit_last) begin
            state_nxt = ST_IDLE;
          end else begin
            emit_nxt = emit_r + NW'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (cmd.emit_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cyc_r       <= '0;
      sc_r        <= '0;
      emit_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cyc_r       <= cyc_nxt;
      sc_r        <= sc_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_load |-> !(out_valid_r && out_stall))
    else $error("activation loaded over a held beat");

  a_sc_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(sc_r) < 32'(MAX_INPUTS))
    else $error("sample counter out of range");

  a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_CLEAR) |=> (state_r != ST_CLEAR))
    else $error("clearing pass re-entered");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_load && cmd.emit_last) |=> (state_r == ST_IDLE) && out_valid_r)
    else $error("vector did not close after last activation");
`endif

endmodule

/* rtl/dls_dp.sv */
// Datapath: weight RAM, shared multiply-accumulate, accumulators, sigmoid lookup, output register.
module dls_dp #(
  parameter  int MAX_NODES   = 16,
  parameter  int MAX_INPUTS  = 64,
  parameter  int TABLE_DEPTH = 256,
  localparam int NW          = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1,
  localparam int SCW         = $clog2(MAX_INPUTS + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dls_pkg::in_item_t   in_data,
  input  dls_pkg::dls_cmd_t   cmd,
  input  logic [NW-1:0]       node_sel,
  input  logic [SCW-1:0]      sample_idx,
  output dls_pkg::dls_stat_t  stat,
  output dls_pkg::out_item_t  out_data
);

  import dls_pkg::*;

  localparam int ROW_LEN = MAX_INPUTS + 1;
  localparam int DEPTH   = MAX_NODES * ROW_LEN;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TIW     = $clog2(TABLE_DEPTH);
  localparam int IDX_OFS = TABLE_DEPTH / 2 - 128;
  localparam int IXW     = 14;
  localparam int QW      = ACC_W - FRAC_W;

  logic [ACT_W-1:0] sig_rom [TABLE_DEPTH];

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_rom
    localparam logic [ACT_W-1:0] ENT = sig_entry(g, TABLE_DEPTH);
    assign sig_rom[g] = ENT;
  end

  logic [AW-1:0]      clr_r, clr_nxt;
  logic               d1_v_r, d2_v_r;
  logic [NW-1:0]      d1_node_r, d2_node_r;
  logic signed [VALUE_W-1:0] v_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [VALUE_W-1:0] bias_r;
  logic signed [ACC_W-1:0]   acc_r [MAX_NODES];
  out_item_t          out_r;

  logic               in_range;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;
  logic [AW-1:0]      raddr_a;
  logic [AW-1:0]      raddr_b;
  logic [VALUE_W-1:0] rdata_a;
  logic [VALUE_W-1:0] rdata_b;

  logic [NW-1:0]           acc_idx;
  logic signed [ACC_W-1:0] acc_rd;
  logic signed [ACC_W-1:0] acc_base;
  logic signed [ACC_W-1:0] acc_sum;
  logic signed [QW-1:0]    q_full;
  logic signed [15:0]      q_sat;
  logic [7:0]              q_top;
  logic signed [IXW-1:0]   idx_s;
  logic [TIW-1:0]          tab_idx;

  assign in_range = (32'(in_data.node_index) < 32'(MAX_NODES)) &&
                    (32'(in_data.weight_index) <= 32'(MAX_INPUTS));

  always_comb begin
    if (cmd.clear_en) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = WEIGHT_RESET;
    end else begin
      ram_we    = cmd.wr_en && in_range;
      ram_waddr = AW'(32'(in_data.node_index) * ROW_LEN + 32'(in_data.weight_index));
      ram_wdata = in_data.value;
    end
  end

  assign raddr_a = AW'(32'(node_sel) * ROW_LEN);
  assign raddr_b = AW'(32'(node_sel) * ROW_LEN + 32'(sample_idx) + 1);

  dls_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_wram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  assign clr_nxt         = cmd.clear_en ? clr_r + AW'(1) : clr_r;
  assign stat.clear_last = (clr_r == AW'(DEPTH - 1));

  assign acc_idx = d2_v_r ? d2_node_r : node_sel;
  assign acc_rd  = acc_r[acc_idx];

  always_comb begin
    if (cmd.first) begin
      acc_base = ACC_W'(bias_r) <<< FRAC_W;
    end else begin
      acc_base = acc_rd;
    end
    acc_sum = acc_base + ACC_W'(prod_r);
  end

  always_comb begin
    q_full = QW'(acc_rd >>> FRAC_W);
    priority if (q_full > QW'(32767)) begin
      q_sat = 16'sd32767;
    end else if (q_full < -QW'(32768)) begin
      q_sat = -16'sd32768;
    end else begin
      q_sat = 16'(q_full);
    end
    q_top = {~q_sat[15], q_sat[14:8]};
    idx_s = $signed(IXW'(q_top)) + $signed(IXW'(IDX_OFS));
    priority if (idx_s < $signed(IXW'(0))) begin
      tab_idx = '0;
    end else if (idx_s > $signed(IXW'(TABLE_DEPTH - 1))) begin
      tab_idx = TIW'(TABLE_DEPTH - 1);
    end else begin
      tab_idx = TIW'(idx_s);
    end
  end

  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r  <= '0;
      d1_v_r <= 1'b0;
      d2_v_r <= 1'b0;
    end else begin
      clr_r  <= clr_nxt;
      d1_v_r <= cmd.issue;
      d2_v_r <= d1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    d1_node_r <= node_sel;
    d2_node_r <= d1_node_r;
    if (cmd.load_sample) begin
      v_r <= in_data.value;
    end
    prod_r <= v_r * $signed(rdata_b);
    bias_r <= $signed(rdata_a);
    if (d2_v_r) begin
      acc_r[d2_node_r] <= acc_sum;
    end
    if (cmd.emit_load) begin
      out_r.neuron     <= 4'(node_sel);
      out_r.activation <= sig_rom[tab_idx];
      out_r.last       <= cmd.emit_last;
    end
  end

`ifndef NO_ASSERTIONS
  a_acc_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(d2_v_r && cmd.emit_load))
    else $error("accumulator update collides with emission");
`endif

endmodule

/* rtl/dense_layer_sigmoid_forward.sv */
// Top level of the dense sigmoid layer: configuration registers and unit wiring.
//
// Input channel (in_valid / in_stall / in_data): mode 0 beats write one Q4.12 weight
// (weight_index 0 is the node's bias), mode 1 beats deliver one Q4.12 feature sample.
// A sample starts a sweep in which the single shared multiply-accumulate visits every
// node accumulator once, fed by the two read ports of the weight RAM. After input_count
// samples (clamped to 1..MAX_INPUTS) the block emits min(max(node_count, 1), MAX_NODES)
// activation beats on out_valid / out_stall / out_data, one per cycle while the receiver
// takes them, in node order, the final one with last set. Input is held off during each
// sweep and while emitting. The output register holds a stalled beat; the next sample
// may enter behind it. Configuration (node_count at 0x0, input_count at 0x4) is written
// over the APB-style cfg_ port; the user must write it only while the block is idle,
// which the block itself does not enforce. pready is tied high and reads return the
// value. After reset all MAX_NODES * (MAX_INPUTS + 1) weight RAM entries (1040 by
// default) are swept to 0.5, one entry per cycle; in_stall stays high meanwhile.
module dense_layer_sigmoid_forward #(
  parameter int MAX_NODES   = dls_pkg::MAX_NODES_DEF,
  parameter int MAX_INPUTS  = dls_pkg::MAX_INPUTS_DEF,
  parameter int TABLE_DEPTH = dls_pkg::TABLE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  dls_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output dls_pkg::out_item_t             out_data,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [dls_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [dls_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [dls_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  import dls_pkg::*;

  localparam int NW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int SCW = $clog2(MAX_INPUTS + 1);

  logic [NODE_COUNT_W-1:0]  node_count_r;
  logic [INPUT_COUNT_W-1:0] input_count_r;
  logic                     cfg_wr;
  logic                     cfg_sel;

  dls_cmd_t       cmd;
  dls_stat_t      stat;
  logic [NW-1:0]  node_sel;
  logic [SCW-1:0] sample_idx;

  assign cfg_pready = 1'b1;
  assign cfg_sel    = cfg_paddr[2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    unique case (cfg_sel)
      REG_NODE_COUNT:  cfg_prdata = CFG_DATA_W'(node_count_r);
      REG_INPUT_COUNT: cfg_prdata = CFG_DATA_W'(input_count_r);
      default:         cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r  <= NODE_COUNT_W'(16);
      input_count_r <= INPUT_COUNT_W'(64);
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_NODE_COUNT:  node_count_r  <= cfg_pwdata[NODE_COUNT_W-1:0];
        REG_INPUT_COUNT: input_count_r <= cfg_pwdata[INPUT_COUNT_W-1:0];
        default:         node_count_r  <= node_count_r;
      endcase
    end
  end

  dls_ctrl #(
    .MAX_NODES  (MAX_NODES),
    .MAX_INPUTS (MAX_INPUTS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_mode     (in_data.mode),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .node_count  (node_count_r),
    .input_count (input_count_r),
    .stat        (stat),
    .cmd         (cmd),
    .node_sel    (node_sel),
    .sample_idx  (sample_idx)
  );

  dls_dp #(
    .MAX_NODES   (MAX_NODES),
    .MAX_INPUTS  (MAX_INPUTS),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .cmd        (cmd),
    .node_sel   (node_sel),
    .sample_idx (sample_idx),
    .stat       (stat),
    .out_data   (out_data)
  );

endmodule
